// ===== rtl/itmv_pkg.sv =====
`timescale 1ns / 1ps

package itmv_pkg;

    localparam int CFG_W     = 13;
    localparam int ACROSS_W  = 7;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 18;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 40;
    localparam int N_W       = 2 * CFG_W;
    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 22;
    localparam int STD_W     = 16;
    localparam int DIV_W     = 64;
    localparam int FRAC_W    = 8;
    localparam int SQRT_IN_W = VAR_W + FRAC_W;

    localparam logic [DIV_W-1:0] MEAN_MAX = DIV_W'(65535);
    localparam logic [DIV_W-1:0] VAR_MAX  = DIV_W'(4194303);

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_TILE_WIDTH   = 3'd1,
        CFG_TILE_HEIGHT  = 3'd2,
        CFG_TILES_ACROSS = 3'd3,
        CFG_TILES_DOWN   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]    image_width;
        logic [CFG_W-1:0]    tile_width;
        logic [CFG_W-1:0]    tile_height;
        logic [ACROSS_W-1:0] tiles_across;
        logic [CFG_W-1:0]    tiles_down;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] tile_index;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  square_sum;
        logic [N_W-1:0]   count;
    } t_tile;

endpackage

// ===== rtl/itmv_queue.sv =====
`timescale 1ns / 1ps

module itmv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  itmv_pkg::t_tile i_data,
    input  logic          i_rd,
    output itmv_pkg::t_tile o_data,
    output logic          o_full,
    output logic          o_empty
);
    import itmv_pkg::*;

    t_tile      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_ok;
    logic       rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) begin
                r_wp <= ~r_wp;
            end
            if (rd_ok) begin
                r_rp <= ~r_rp;
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/itmv_front.sv =====
`timescale 1ns / 1ps

module itmv_front #(
    parameter int MAX_TILES_ACROSS = 64,
    parameter int MAX_DIMENSION    = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itmv_pkg::t_cfg                i_cfg,
    input  logic                          i_cfg_we,
    input  logic                          i_push,
    input  logic [itmv_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_frame_start,
    output logic                          o_full,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output itmv_pkg::t_tile               o_q_data
);
    import itmv_pkg::*;

    localparam int AW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
    localparam int RW = $clog2(MAX_DIMENSION + 1);
    localparam int CW = (RW > CFG_W) ? RW : CFG_W;
    localparam int SW = $clog2(CW + 1);
    localparam logic [CW-1:0] MAXD  = CW'(MAX_DIMENSION);
    localparam logic [CW-1:0] MAXTA = CW'(MAX_TILES_ACROSS);

    typedef enum logic [1:0] {F_IDLE, F_EXEC, F_SYNC} t_state;

    t_state r_state;
    logic   r_pend;
    logic [SW-1:0] r_cnt;
    logic [CW-1:0] r_col, r_cx, r_tc, r_row, r_ry, r_tr;
    logic [PIX_W-1:0] r_pix;
    logic   r_fs, r_hit, r_done;
    logic [AW-1:0] r_addr;
    logic [IDX_W-1:0] r_idx;
    logic [N_W-1:0] r_n;
    logic [MAX_TILES_ACROSS-1:0] r_vld;
    logic   r_rd_v;
    logic [SUM_W-1:0] r_rd_sum;
    logic [SQ_W-1:0]  r_rd_sq;
    logic [SUM_W-1:0] mem_sum [MAX_TILES_ACROSS];
    logic [SQ_W-1:0]  mem_sq  [MAX_TILES_ACROSS];

    logic accept;
    logic [CW-1:0] c_col, c_cx, c_tc, c_row, c_ry, c_tr;
    logic [CW-1:0] iw, w, tw, th, tw_m1, th_m1, ac, td;
    logic hit, done, row_end;
    logic [CW-1:0] n_col, n_cx, n_tc, n_row, n_ry, n_tr;
    logic [2*CW-1:0] prod;
    logic [AW-1:0] rd_addr;
    logic [SUM_W-1:0] base_sum, new_sum, w_sum;
    logic [SQ_W-1:0]  base_sq, new_sq, w_sq;
    logic [MAX_TILES_ACROSS-1:0] n_vld;
    logic [CFG_W:0] st_c, st_r, df_c, df_r;
    logic ge_c, ge_r;

    assign o_full = (r_state != F_IDLE) || r_pend || i_q_full;
    assign accept = i_push && !o_full;

    always_comb begin
        c_col = i_frame_start ? '0 : r_col;
        c_cx  = i_frame_start ? '0 : r_cx;
        c_tc  = i_frame_start ? '0 : r_tc;
        c_row = i_frame_start ? '0 : r_row;
        c_ry  = i_frame_start ? '0 : r_ry;
        c_tr  = i_frame_start ? '0 : r_tr;
        iw    = CW'(i_cfg.image_width);
        w     = (iw == '0) ? CW'(1) : iw;
        if (w > MAXD) begin
            w = MAXD;
        end
        tw    = CW'(i_cfg.tile_width);
        th    = CW'(i_cfg.tile_height);
        tw_m1 = CW'(CFG_W'(i_cfg.tile_width - CFG_W'(1)));
        th_m1 = CW'(CFG_W'(i_cfg.tile_height - CFG_W'(1)));
        ac    = (CW'(i_cfg.tiles_across) > MAXTA) ? MAXTA : CW'(i_cfg.tiles_across);
        td    = CW'(i_cfg.tiles_down);
        hit   = (c_row < MAXD) && (tw != '0) && (th != '0) && (ac != '0) && (td != '0)
                && (c_tc < ac) && (c_tr < td);
        done  = hit && (c_cx == tw_m1) && (c_ry == th_m1);
        prod  = c_tr * ac;
        rd_addr = c_tc[AW-1:0];

        row_end = ((c_col + CW'(1)) >= w);
        n_row = c_row;
        n_ry  = c_ry;
        n_tr  = c_tr;
        if (row_end) begin
            n_col = '0;
            n_cx  = '0;
            n_tc  = '0;
            if (c_row < MAXD) begin
                n_row = c_row + CW'(1);
                if (c_ry == th_m1) begin
                    n_ry = '0;
                    n_tr = c_tr + CW'(1);
                end else begin
                    n_ry = c_ry + CW'(1);
                end
            end
        end else begin
            n_col = c_col + CW'(1);
            if (c_cx == tw_m1) begin
                n_cx = '0;
                n_tc = c_tc + CW'(1);
            end else begin
                n_cx = c_cx + CW'(1);
                n_tc = c_tc;
            end
        end

        base_sum = (r_rd_v && !r_fs) ? r_rd_sum : '0;
        base_sq  = (r_rd_v && !r_fs) ? r_rd_sq : '0;
        new_sum  = base_sum + SUM_W'(r_pix);
        new_sq   = base_sq + SQ_W'(r_pix) * SQ_W'(r_pix);
        w_sum    = r_done ? '0 : new_sum;
        w_sq     = r_done ? '0 : new_sq;
        n_vld    = r_fs ? '0 : r_vld;
        if (r_hit) begin
            n_vld[r_addr] = 1'b1;
        end

        st_c = {r_cx[CFG_W-1:0], r_tc[CW-1]};
        st_r = {r_ry[CFG_W-1:0], r_tr[CW-1]};
        ge_c = (st_c >= {1'b0, i_cfg.tile_width});
        ge_r = (st_r >= {1'b0, i_cfg.tile_height});
        df_c = st_c - {1'b0, i_cfg.tile_width};
        df_r = st_r - {1'b0, i_cfg.tile_height};
    end

    assign o_q_push            = (r_state == F_EXEC) && r_done;
    assign o_q_data.tile_index = r_idx;
    assign o_q_data.sum        = new_sum;
    assign o_q_data.square_sum = new_sq;
    assign o_q_data.count      = r_n;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_sum <= mem_sum[rd_addr];
            r_rd_sq  <= mem_sq[rd_addr];
        end
        if ((r_state == F_EXEC) && r_hit) begin
            mem_sum[r_addr] <= w_sum;
            mem_sq[r_addr]  <= w_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_col   <= '0;
            r_cx    <= '0;
            r_tc    <= '0;
            r_row   <= '0;
            r_ry    <= '0;
            r_tr    <= '0;
            r_vld   <= '0;
            r_fs    <= 1'b0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (r_pend) begin
                        r_pend  <= 1'b0;
                        r_cnt   <= '0;
                        r_tc    <= r_col;
                        r_cx    <= '0;
                        r_tr    <= r_row;
                        r_ry    <= '0;
                        r_state <= F_SYNC;
                    end else if (accept) begin
                        r_col   <= n_col;
                        r_cx    <= n_cx;
                        r_tc    <= n_tc;
                        r_row   <= n_row;
                        r_ry    <= n_ry;
                        r_tr    <= n_tr;
                        r_pix   <= i_pixel;
                        r_fs    <= i_frame_start;
                        r_hit   <= hit;
                        r_done  <= done;
                        r_addr  <= rd_addr;
                        r_idx   <= IDX_W'(prod + (2*CW)'(c_tc));
                        r_n     <= i_cfg.tile_width * i_cfg.tile_height;
                        r_rd_v  <= r_vld[rd_addr];
                        r_state <= F_EXEC;
                    end
                end
                F_EXEC: begin
                    r_vld   <= n_vld;
                    r_state <= F_IDLE;
                end
                F_SYNC: begin
                    r_tc  <= {r_tc[CW-2:0], ge_c};
                    r_tr  <= {r_tr[CW-2:0], ge_r};
                    r_cx  <= CW'(ge_c ? df_c[CFG_W-1:0] : st_c[CFG_W-1:0]);
                    r_ry  <= CW'(ge_r ? df_r[CFG_W-1:0] : st_r[CFG_W-1:0]);
                    r_cnt <= r_cnt + SW'(1);
                    if (r_cnt == SW'(CW - 1)) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
            if (i_cfg_we) begin
                r_pend <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/itmv_div.sv =====
`timescale 1ns / 1ps

module itmv_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [itmv_pkg::DIV_W-1:0]  i_dividend,
    input  logic [itmv_pkg::N_W-1:0]    i_divisor,
    output logic                        o_done,
    output logic [itmv_pkg::DIV_W-1:0]  o_quot,
    output logic [itmv_pkg::N_W-1:0]    o_rem
);
    import itmv_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quot;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_div;
    logic [N_W:0]     t;
    logic [N_W:0]     diff;
    logic             ge;

    always_comb begin
        t    = {r_rem, r_quot[DIV_W-1]};
        ge   = (t >= {1'b0, r_div});
        diff = t - {1'b0, r_div};
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[N_W-1:0] : t[N_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], ge};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/itmv_sqrt.sv =====
`timescale 1ns / 1ps

module itmv_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [itmv_pkg::SQRT_IN_W-1:0]  i_value,
    output logic                            o_done,
    output logic [itmv_pkg::STD_W-1:0]      o_root
);
    import itmv_pkg::*;

    localparam int STEPS = SQRT_IN_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam int RM_W  = STD_W + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [SQRT_IN_W-1:0] r_src;
    logic [RM_W-1:0]      r_rem;
    logic [STD_W-1:0]     r_root;
    logic [RM_W+1:0]      t;
    logic [RM_W+1:0]      trial;
    logic [RM_W+1:0]      diff;
    logic                 ge;

    always_comb begin
        t     = {r_rem, r_src[SQRT_IN_W-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        ge    = (t >= trial);
        diff  = t - trial;
    end

    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_src  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_src  <= {r_src[SQRT_IN_W-3:0], 2'b00};
                r_rem  <= ge ? diff[RM_W-1:0] : t[RM_W-1:0];
                r_root <= {r_root[STD_W-2:0], ge};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/itmv_back.sv =====
`timescale 1ns / 1ps

module itmv_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  itmv_pkg::t_tile              i_q_data,
    output logic                         o_q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic [itmv_pkg::IDX_W-1:0]   o_tile_index,
    output logic [itmv_pkg::MEAN_W-1:0]  o_mean_q8,
    output logic [itmv_pkg::VAR_W-1:0]   o_variance_q8,
    output logic [itmv_pkg::STD_W-1:0]   o_std_dev_q8
);
    import itmv_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_SQUARE, B_QA_GO, B_QA_WAIT, B_MEAN_WAIT, B_R_WAIT,
        B_V_WAIT, B_SQ_GO, B_SQ_WAIT, B_OUT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic [SUM_W-1:0] r_s;
    logic [SQ_W-1:0]  r_q;
    logic [N_W-1:0]   r_n;
    logic [DIV_W-1:0] r_s2;
    logic [DIV_W-1:0] r_qa;
    logic [N_W-1:0]   r_ra;
    logic [SQ_W-1:0]  r_q1;
    logic [MEAN_W-1:0] r_mean;
    logic [VAR_W-1:0] r_var;
    logic             r_go;
    logic [DIV_W-1:0] r_div_a;
    logic             r_sq_go;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic [MEAN_W-1:0] r_o_mean;
    logic [VAR_W-1:0] r_o_var;
    logic [STD_W-1:0] r_o_std;

    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [N_W-1:0]   div_rem;
    logic             sq_done;
    logic [STD_W-1:0] sq_root;
    logic             var_ok;
    logic [N_W-1:0]   r1;
    logic [SQ_W-1:0]  q1;

    itmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_go),
        .i_dividend (r_div_a),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    itmv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_value ({r_var, {FRAC_W{1'b0}}}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        var_ok = (r_qa < DIV_W'(r_q)) || ((r_qa == DIV_W'(r_q)) && (r_ra == '0));
        r1     = (r_ra == '0) ? '0 : (r_n - r_ra);
        q1     = r_q - r_qa[SQ_W-1:0] - SQ_W'(r_ra != '0);
    end

    assign o_q_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign empty         = !r_out_valid;
    assign o_tile_index  = r_o_idx;
    assign o_mean_q8     = r_o_mean;
    assign o_variance_q8 = r_o_var;
    assign o_std_dev_q8  = r_o_std;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_go        <= 1'b0;
            r_sq_go     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            r_sq_go <= 1'b0;
            if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_idx   <= i_q_data.tile_index;
                        r_s     <= i_q_data.sum;
                        r_q     <= i_q_data.square_sum;
                        r_n     <= i_q_data.count;
                        r_state <= B_SQUARE;
                    end
                end
                B_SQUARE: begin
                    r_s2    <= r_s * r_s;
                    r_state <= B_QA_GO;
                end
                B_QA_GO: begin
                    r_div_a <= r_s2;
                    r_go    <= 1'b1;
                    r_state <= B_QA_WAIT;
                end
                B_QA_WAIT: begin
                    if (div_done) begin
                        r_qa    <= div_quot;
                        r_ra    <= div_rem;
                        r_div_a <= DIV_W'({r_s, {FRAC_W{1'b0}}});
                        r_go    <= 1'b1;
                        r_state <= B_MEAN_WAIT;
                    end
                end
                B_MEAN_WAIT: begin
                    if (div_done) begin
                        r_mean <= (div_quot > MEAN_MAX) ? MEAN_W'(MEAN_MAX)
                                                        : div_quot[MEAN_W-1:0];
                        if (var_ok) begin
                            r_q1    <= q1;
                            r_div_a <= DIV_W'({r1, {FRAC_W{1'b0}}});
                            r_go    <= 1'b1;
                            r_state <= B_R_WAIT;
                        end else begin
                            r_var   <= '0;
                            r_state <= B_SQ_GO;
                        end
                    end
                end
                B_R_WAIT: begin
                    if (div_done) begin
                        r_div_a <= DIV_W'({r_q1, {FRAC_W{1'b0}}}) + div_quot;
                        r_go    <= 1'b1;
                        r_state <= B_V_WAIT;
                    end
                end
                B_V_WAIT: begin
                    if (div_done) begin
                        r_var   <= (div_quot > VAR_MAX) ? VAR_W'(VAR_MAX)
                                                        : div_quot[VAR_W-1:0];
                        r_state <= B_SQ_GO;
                    end
                end
                B_SQ_GO: begin
                    r_sq_go <= 1'b1;
                    r_state <= B_SQ_WAIT;
                end
                B_SQ_WAIT: begin
                    if (sq_done) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!r_out_valid || pop) begin
                        r_o_idx     <= r_idx;
                        r_o_mean    <= r_mean;
                        r_o_var     <= r_var;
                        r_o_std     <= sq_root;
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/image_tile_mean_variance.sv =====
`timescale 1ns / 1ps

// Pixels enter in raster order through a queue-style port; a tile result comes out
// when the bottom-right pixel of a tile has been taken. The front end takes a new
// pixel only after it has finished the last one (one read of the per-column sum
// memory, then its update). After any configuration write it re-derives the tile
// coordinates one position bit per step (13 bits at the default size) before it
// takes the next pixel. Each finished tile then passes through the back end: up to
// four 64-step divisions on one shared divider (two when the variance is clamped to
// zero) and a 15-step square root. A queue of two finished tiles sits between the
// two ends, and a single output register holds the oldest result until it is popped.
module image_tile_mean_variance #(
    parameter int MAX_TILES_ACROSS = 64,
    parameter int MAX_DIMENSION    = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_index,
    input  logic [itmv_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [itmv_pkg::PIX_W-1:0]   i_pixel,
    input  logic                         i_frame_start,
    output logic                         empty,
    input  logic                         pop,
    output logic [itmv_pkg::IDX_W-1:0]   o_tile_index,
    output logic [itmv_pkg::MEAN_W-1:0]  o_mean_q8,
    output logic [itmv_pkg::VAR_W-1:0]   o_variance_q8,
    output logic [itmv_pkg::STD_W-1:0]   o_std_dev_q8
);
    import itmv_pkg::*;

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    t_tile q_wdata;
    t_tile q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= CFG_W'(512);
            r_cfg.tile_width   <= CFG_W'(64);
            r_cfg.tile_height  <= CFG_W'(64);
            r_cfg.tiles_across <= ACROSS_W'(8);
            r_cfg.tiles_down   <= CFG_W'(8);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_TILE_WIDTH:   r_cfg.tile_width   <= i_cfg_data;
                CFG_TILE_HEIGHT:  r_cfg.tile_height  <= i_cfg_data;
                CFG_TILES_ACROSS: r_cfg.tiles_across <= i_cfg_data[ACROSS_W-1:0];
                CFG_TILES_DOWN:   r_cfg.tiles_down   <= i_cfg_data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    itmv_front #(
        .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
        .MAX_DIMENSION    (MAX_DIMENSION)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cfg_we      (i_cfg_we),
        .i_push        (push),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    itmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_data  (q_wdata),
        .i_rd    (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    itmv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_tile_index  (o_tile_index),
        .o_mean_q8     (o_mean_q8),
        .o_variance_q8 (o_variance_q8),
        .o_std_dev_q8  (o_std_dev_q8)
    );

endmodule
